### sv/rtnp_pkg.sv
// ----------------------------------------------------------------------------
// rtnp_pkg: ringtone note parser shared definitions
// Character codes, phase encoding, register indexes, state and result
// structs, and the letter to semitone table.
// ----------------------------------------------------------------------------
package rtnp_pkg;

  // character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_DOT   = 8'h2e;  // '.'
  localparam logic [7:0] CH_COMMA = 8'h2c;  // ','
  localparam logic [7:0] CH_SEMI  = 8'h3b;  // ';'
  localparam logic [7:0] CH_CARET = 8'h5e;  // '^'
  localparam logic [7:0] CH_A     = 8'h61;  // 'a'
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_G     = 8'h67;  // 'g'
  localparam logic [7:0] CH_P     = 8'h70;  // 'p'

  // semitone codes
  localparam logic [7:0] PITCH_A     = 8'd9;
  localparam logic [7:0] PITCH_B     = 8'd11;
  localparam logic [7:0] PITCH_C     = 8'd0;
  localparam logic [7:0] PITCH_D     = 8'd2;
  localparam logic [7:0] PITCH_E     = 8'd4;
  localparam logic [7:0] PITCH_F     = 8'd5;
  localparam logic [7:0] PITCH_G     = 8'd7;
  localparam logic [7:0] PITCH_PAUSE = 8'd12;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_DURATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_OCTAVE   = 2'd1;
  localparam logic [3:0] DEFAULT_DURATION_RST = 4'd4;
  localparam logic [3:0] DEFAULT_OCTAVE_RST   = 4'd6;

  typedef enum logic [1:0] {
    PH_INITIAL  = 2'd0,
    PH_DURATION = 2'd1,
    PH_PITCH    = 2'd2,
    PH_OCTAVE   = 2'd3
  } phase_t;

  // per-song parser state
  typedef struct packed {
    phase_t     phase;
    logic [7:0] duration;
    logic [7:0] pitch;
    logic [3:0] octave;
    logic [7:0] count;
    logic       first_seen;
  } parse_state_t;

  // one result beat
  typedef struct packed {
    logic [7:0] duration;
    logic [7:0] pitch;
    logic [3:0] octave;
    logic [7:0] index;
    logic       song_end;
  } note_t;

  // letter to semitone, msb flags a valid letter
  function automatic logic [8:0] letter_pitch(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      CH_A:    r = {1'b1, PITCH_A};
      CH_B:    r = {1'b1, PITCH_B};
      CH_C:    r = {1'b1, PITCH_C};
      CH_D:    r = {1'b1, PITCH_D};
      CH_E:    r = {1'b1, PITCH_E};
      CH_F:    r = {1'b1, PITCH_F};
      CH_G:    r = {1'b1, PITCH_G};
      CH_P:    r = {1'b1, PITCH_PAUSE};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

### sv/rtnp_step.sv
// ----------------------------------------------------------------------------
// rtnp_step: one character step of the note parser
// Pure next-state and result logic for one character against the current
// parser state and the configured defaults.
// ----------------------------------------------------------------------------
module rtnp_step (
  input  logic [7:0]            char_i,
  input  rtnp_pkg::parse_state_t st_i,
  input  logic [3:0]            def_duration_i,
  input  logic [3:0]            def_octave_i,
  output rtnp_pkg::parse_state_t st_o,
  output logic                  res_vld_o,
  output rtnp_pkg::note_t       res_o
);
  import rtnp_pkg::*;

  logic       is_digit19;
  logic       is_digit09;
  logic       is_end;
  logic [8:0] letter;
  logic [7:0] digit_val;
  logic [7:0] dur_x10;
  logic [7:0] emit_dur;
  logic [3:0] emit_oct;

  // character classes
  assign is_digit19 = (char_i >= CH_ONE) && (char_i <= CH_NINE);
  assign is_digit09 = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
  assign is_end     = (char_i == CH_SEMI) || (char_i == CH_CARET);
  assign letter     = letter_pitch(char_i);
  assign digit_val  = {4'd0, char_i[3:0]};
  assign dur_x10    = (st_i.duration << 3) + (st_i.duration << 1);

  // duration and octave of a completed note, zero takes the default
  assign emit_dur = (st_i.duration == 8'd0) ? {4'd0, def_duration_i} : st_i.duration;
  assign emit_oct = (st_i.octave == 4'd0) ? def_octave_i : st_i.octave;

  always_comb begin
    st_o      = st_i;
    res_vld_o = 1'b0;
    res_o     = '0;
    if (st_i.first_seen && is_end) begin
      // end of song: report count, drop partial note, start over
      res_vld_o     = 1'b1;
      res_o.index    = st_i.count;
      res_o.song_end = 1'b1;
      st_o           = '0;
    end else begin
      st_o.first_seen = 1'b1;
      case (st_i.phase)
        PH_INITIAL: begin
          st_o.duration = 8'd0;
          st_o.octave   = 4'd0;
          st_o.pitch    = 8'd0;
          if (is_digit19) begin
            st_o.duration = digit_val;
            st_o.phase    = PH_DURATION;
          end else if (letter[8]) begin
            st_o.pitch    = letter[7:0];
            st_o.duration = {4'd0, def_duration_i};
            st_o.phase    = PH_PITCH;
          end
        end
        PH_DURATION: begin
          if (is_digit19) begin
            st_o.duration = dur_x10 + digit_val;
          end else begin
            st_o.phase = PH_PITCH;
            if (letter[8]) begin
              st_o.pitch = letter[7:0];
            end
          end
        end
        PH_PITCH: begin
          if (char_i == CH_HASH) begin
            st_o.pitch = st_i.pitch + 8'd1;
          end else if (char_i == CH_DOT) begin
            st_o.duration = st_i.duration << 1;
          end else if (is_digit09) begin
            st_o.octave = char_i[3:0];
            st_o.phase  = PH_OCTAVE;
          end else if (char_i == CH_COMMA) begin
            // comma closes the note at once with the default octave
            res_vld_o      = 1'b1;
            res_o.duration = emit_dur;
            res_o.pitch    = st_i.pitch;
            res_o.octave   = def_octave_i;
            res_o.index    = st_i.count;
            st_o.duration  = emit_dur;
            st_o.octave    = def_octave_i;
            st_o.count     = st_i.count + 8'd1;
            st_o.phase     = PH_INITIAL;
          end
        end
        PH_OCTAVE: begin
          // any character but ';' or '^' closes the note and is consumed
          res_vld_o      = 1'b1;
          res_o.duration = emit_dur;
          res_o.pitch    = st_i.pitch;
          res_o.octave   = emit_oct;
          res_o.index    = st_i.count;
          st_o.duration  = emit_dur;
          st_o.octave    = emit_oct;
          st_o.count     = st_i.count + 8'd1;
          st_o.phase     = PH_INITIAL;
        end
        default: begin
          st_o = st_i;
        end
      endcase
    end
  end

endmodule

### sv/ringtone_note_parser_core.sv
// ----------------------------------------------------------------------------
// ringtone_note_parser_core: ringtone note body parser
// Parses note characters into notes and end-of-song markers.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/stall   | character
//  out_    | output    | out_valid/stall  | duration, pitch, octave, index, end
//  cfg_    | input     | cfg_valid/ready  | index, data (default dur/octave)
//
//  One character per cycle unless stalled: a beat sits in the input register,
//  the step logic updates parser state, and a result lands in the output
//  register; a stall can hold a character between the two registers.
//  A waiting result stalls only characters that would also make a result.
//  Synchronous active-low reset restores the defaults and clears the song.
// ----------------------------------------------------------------------------
module ringtone_note_parser_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_character,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_note_duration,
  output logic [7:0]                         out_note_pitch,
  output logic [3:0]                         out_note_octave,
  output logic [7:0]                         out_note_index,
  output logic                               out_song_end,
  // configuration
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rtnp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rtnp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rtnp_pkg::*;

  logic         in_vld_r, in_vld_nxt;
  logic [7:0]   in_char_r;
  logic         out_vld_r, out_vld_nxt;
  note_t        out_r;
  parse_state_t st_r, st_nxt;
  logic [3:0]   def_dur_r, def_oct_r;
  logic         step_vld;
  note_t        step_res;
  logic         out_free;
  logic         advance;
  logic         in_take;

  // step logic
  rtnp_step u_step (
    .char_i         (in_char_r),
    .st_i           (st_r),
    .def_duration_i (def_dur_r),
    .def_octave_i   (def_oct_r),
    .st_o           (st_nxt),
    .res_vld_o      (step_vld),
    .res_o          (step_res)
  );

  // flow control
  assign out_free  = !out_vld_r || !out_stall;
  assign advance   = in_vld_r && (!step_vld || out_free);
  assign in_stall  = in_vld_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign in_vld_nxt  = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_r);
  assign out_vld_nxt = (advance && step_vld) ? 1'b1 : (out_free ? 1'b0 : out_vld_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= '0;
      def_dur_r <= DEFAULT_DURATION_RST;
      def_oct_r <= DEFAULT_OCTAVE_RST;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DEFAULT_DURATION: def_dur_r <= cfg_data;
          CFG_DEFAULT_OCTAVE:   def_oct_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_char_r <= in_character;
    end
    if (advance && step_vld) begin
      out_r <= step_res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_note_duration = out_r.duration;
  assign out_note_pitch    = out_r.pitch;
  assign out_note_octave   = out_r.octave;
  assign out_note_index    = out_r.index;
  assign out_song_end      = out_r.song_end;

endmodule
